FILE: hdl/cmv_pkg.sv
// shared types and constants for the codebook int4 matrix-vector block
// no dependencies; used by the channel interfaces and the top level
package cmv_pkg;

  // field widths fixed by the block definition
  localparam int ROW_W     = 16;
  localparam int COLCNT_W  = 13;
  localparam int VIDX_W    = 12;
  localparam int WORD_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int SUM_W     = 60;
  localparam int CB_REG_W  = 64;
  localparam int CB_REGS   = 4;
  localparam int PDATA_W   = 64;
  localparam int PADDR_W   = 6;

  // low nibble selection mask
  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  // request action codes
  localparam logic ACT_VEC_WRITE = 1'b0;
  localparam logic ACT_WEIGHT    = 1'b1;

  // register indexes (byte address is 8 times the index)
  localparam logic [2:0] REG_ROW_COUNT    = 3'd0;
  localparam logic [2:0] REG_COLUMN_COUNT = 3'd1;
  localparam logic [2:0] REG_CODEBOOK_A   = 3'd2;
  localparam logic [2:0] REG_CODEBOOK_B   = 3'd3;
  localparam logic [2:0] REG_CODEBOOK_C   = 3'd4;
  localparam logic [2:0] REG_CODEBOOK_D   = 3'd5;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [ROW_W-1:0]         row_t;

endpackage

FILE: hdl/cmv_in_if.sv
// request channel: vector writes and packed weight bytes
// depends on cmv_pkg
interface cmv_in_if import cmv_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                action;
  logic [VIDX_W-1:0]   vec_index;
  word_t               vec_value;
  logic [BYTE_W-1:0]   packed_weights;
  word_t               group_scale;

  modport source (output valid, action, vec_index, vec_value, packed_weights, group_scale,
                  input ready);
  modport sink   (input valid, action, vec_index, vec_value, packed_weights, group_scale,
                  output ready);
endinterface

FILE: hdl/cmv_out_if.sv
// result channel: one finished row sum per transfer
// depends on cmv_pkg
interface cmv_out_if import cmv_pkg::*; ();
  logic  valid;
  logic  ready;
  row_t  row_index;
  sum_t  row_sum;
  logic  last_row;
  logic  last;

  modport source (output valid, row_index, row_sum, last_row, last, input ready);
  modport sink   (input valid, row_index, row_sum, last_row, last, output ready);
endinterface

FILE: hdl/codebook_int4_matvec.sv
// Codebook int4 matrix-vector multiply: vector store, row accumulation, APB registers.
// A vector write is stored when accepted. A weight byte is accepted in idle; each nibble,
// low first, then takes a vector-store read, a product step and an accumulate step, set by
// the single store read port and the two-multiply chain. The high nibble is skipped if the
// low one ends the last row; no request is taken until idle. A row result that meets a
// still-occupied output register holds the accumulate step until taken. The vector store
// needs no clearing pass after reset. Depends on cmv_pkg, cmv_in_if and cmv_out_if.
module codebook_int4_matvec import cmv_pkg::*; #(
  parameter int MAX_COLUMNS = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  cmv_in_if.sink              item,
  cmv_out_if.source           result
);

  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int CNT_W = CW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_ACC  = 2'd3;

  // configuration registers
  logic [ROW_W-1:0]    row_count;
  logic [COLCNT_W-1:0] column_count;
  logic [CB_REG_W-1:0] cb_regs [CB_REGS];

  // control and datapath registers
  logic [1:0]              state;
  logic                    nib;
  logic [BYTE_W-1:0]       byte_q;
  word_t                   scale_q;
  logic signed [31:0]      pmul;
  logic signed [47:0]      prod;
  sum_t                    acc;
  logic [CW-1:0]           col_pos;
  row_t                    row_pos;
  logic [WORD_W-1:0]       rdata;

  // output register
  logic  out_valid;
  row_t  out_row_index;
  sum_t  out_row_sum;
  logic  out_last_row;
  logic  out_last;

  // vector store
  logic [WORD_W-1:0] vstore [MAX_COLUMNS];

  logic [2:0]        reg_idx;
  logic              cfg_wr;
  logic              accept;
  logic [31:0]       cols_full;
  logic [CNT_W-1:0]  cols_eff;
  logic [CNT_W-1:0]  cols_m1;
  logic [CNT_W-1:0]  col_inc;
  logic [CW-1:0]     raddr;
  logic [31:0]       vidx_full;
  logic [3:0]        nib_code;
  word_t             cb_word;
  sum_t              sum_new;
  logic              row_end;
  logic              final_row;
  logic              stall;
  logic              load_out;
  logic              empty_matrix;

  // apb access
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_ROW_COUNT:    prdata = PDATA_W'(row_count);
      REG_COLUMN_COUNT: prdata = PDATA_W'(column_count);
      REG_CODEBOOK_A:   prdata = cb_regs[0];
      REG_CODEBOOK_B:   prdata = cb_regs[1];
      REG_CODEBOOK_C:   prdata = cb_regs[2];
      REG_CODEBOOK_D:   prdata = cb_regs[3];
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= '0;
      column_count <= '0;
      for (int i = 0; i < CB_REGS; i++) begin
        cb_regs[i] <= '0;
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ROW_COUNT:    row_count    <= pwdata[ROW_W-1:0];
        REG_COLUMN_COUNT: column_count <= pwdata[COLCNT_W-1:0];
        REG_CODEBOOK_A:   cb_regs[0]   <= pwdata;
        REG_CODEBOOK_B:   cb_regs[1]   <= pwdata;
        REG_CODEBOOK_C:   cb_regs[2]   <= pwdata;
        REG_CODEBOOK_D:   cb_regs[3]   <= pwdata;
        default: ;
      endcase
    end
  end

  // effective column count, clamped to the store depth
  assign cols_full = 32'(column_count);
  assign cols_eff  = (cols_full > 32'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS)
                                                    : cols_full[CNT_W-1:0];
  assign cols_m1   = cols_eff - CNT_W'(1);
  assign col_inc   = {1'b0, col_pos} + CNT_W'(1);
  assign raddr     = ({1'b0, col_pos} >= cols_eff) ? cols_m1[CW-1:0] : col_pos;

  assign empty_matrix = (row_count == '0) || (cols_eff == '0);
  assign item.ready   = (state == S_IDLE);
  assign accept       = item.valid && item.ready;
  assign vidx_full    = 32'(item.vec_index);

  // codebook lookup for the current nibble
  assign nib_code = nib ? (byte_q[7:4] & NIBBLE_MASK) : (byte_q[3:0] & NIBBLE_MASK);
  assign cb_word  = word_t'(cb_regs[nib_code[3:2]][{nib_code[1:0], 4'b0000} +: WORD_W]);

  // accumulate step
  assign sum_new   = acc + SUM_W'(prod);
  assign row_end   = (col_inc >= cols_eff);
  assign final_row = ((ROW_W+1)'(row_pos) + (ROW_W+1)'(1)) >= (ROW_W+1)'(row_count);
  assign stall     = row_end && out_valid && !result.ready;
  assign load_out  = (state == S_ACC) && row_end && !stall;

  // vector store write and registered read
  always_ff @(posedge clk) begin
    if (accept && item.action == ACT_VEC_WRITE && vidx_full < 32'(MAX_COLUMNS)) begin
      vstore[vidx_full[CW-1:0]] <= item.vec_value;
    end
    if (state == S_READ) begin
      rdata <= vstore[raddr];
    end
  end

  // sequencer: read, multiply, accumulate per nibble
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      nib     <= 1'b0;
      acc     <= '0;
      col_pos <= '0;
      row_pos <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && item.action == ACT_WEIGHT && !empty_matrix) begin
            state <= S_READ;
            nib   <= 1'b0;
          end
        end
        S_READ: begin
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (!stall) begin
            if (row_end) begin
              acc     <= '0;
              col_pos <= '0;
              row_pos <= final_row ? '0 : row_pos + ROW_W'(1);
              if (nib || final_row) begin
                state <= S_IDLE;
              end else begin
                state <= S_READ;
                nib   <= 1'b1;
              end
            end else begin
              acc     <= sum_new;
              col_pos <= col_inc[CW-1:0];
              if (nib) begin
                state <= S_IDLE;
              end else begin
                state <= S_READ;
                nib   <= 1'b1;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload capture and product pipeline
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q  <= item.packed_weights;
      scale_q <= item.group_scale;
    end
    if (state == S_READ) begin
      pmul <= cb_word * scale_q;
    end
    if (state == S_MUL) begin
      prod <= pmul * word_t'(rdata);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_row_index <= row_pos;
      out_row_sum   <= sum_new;
      out_last_row  <= final_row;
      out_last      <= nib || final_row || (cols_eff != CNT_W'(1));
    end
  end

  assign result.valid     = out_valid;
  assign result.row_index = out_row_index;
  assign result.row_sum   = out_row_sum;
  assign result.last_row  = out_last_row;
  assign result.last      = out_last;

`ifndef SYNTHESIS
  // a held result is never overwritten
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACC && row_end && out_valid && !result.ready) |=> (state == S_ACC))
    else $error("row result lost while output register occupied");

  // every read is followed by its product step
  a_read_then_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_MUL))
    else $error("read not followed by product step");

  // accumulator restarts after a finished row
  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
    load_out |=> (acc == '0 && col_pos == '0))
    else $error("accumulator not cleared after row end");

  // end of matrix returns to the first row and the idle state
  a_matrix_wrap: assert property (@(posedge clk) disable iff (rst)
    (load_out && final_row) |=> (row_pos == '0 && state == S_IDLE))
    else $error("matrix end did not wrap positions");
`endif

endmodule
